// ===== src/hvss_pkg.sv =====
// Shared types and constants of the segment sweep intersection core.
`default_nettype none
package hvss_pkg;

    localparam int MAX_ACTIVE  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(MAX_ACTIVE);
    localparam int CNT_W       = $clog2(MAX_ACTIVE + 1);
    localparam int HIT_W       = $clog2(MAX_RESULTS + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [IDX_W-1:0]             t_idx;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef enum logic [1:0] {
        K_END   = 2'd0,
        K_VERT  = 2'd1,
        K_START = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_CMP,
        S_VRT_RD,
        S_VRT_CMP,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic   we;
        t_idx   waddr;
        t_coord wdata;
        logic   re;
        t_idx   raddr;
    } t_mem_req;

    typedef struct packed {
        logic gt_lo;
        logic eq_lo;
        logic lt_hi;
    } t_cmp_res;

endpackage
`default_nettype wire

// ===== src/hvss_mem.sv =====
// Store of active y values: one write port, one registered read port.
`default_nettype none
module hvss_mem
    import hvss_pkg::*;
(
    input  wire           i_clk,
    input  wire t_mem_req i_req,
    output t_coord        o_rdata
);

    t_coord r_mem [MAX_ACTIVE];
    t_coord r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== src/hvss_cmp.sv =====
// Shared signed compare unit: stored y against the event's two keys.
`default_nettype none
module hvss_cmp
    import hvss_pkg::*;
(
    input  wire t_coord i_data,
    input  wire t_coord i_key_lo,
    input  wire t_coord i_key_hi,
    output t_cmp_res    o_res
);

    always_comb begin
        o_res.gt_lo = (i_data > i_key_lo);
        o_res.eq_lo = (i_data == i_key_lo);
        o_res.lt_hi = (i_data < i_key_hi);
    end

endmodule
`default_nettype wire

// ===== src/hv_segment_sweep_intersect_core.sv =====
// Sweep-line core: sorted store of active y values, emits vertical crossings.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_kind, i_x, i_y_low, i_y_high
//  out     | output    | o_out_valid / i_out_ready  | o_hit_x, o_hit_y, o_last, o_overflowed
//
// Start: each entry above the insert point is read and moved up one slot, then the
// new y is written; a full store only sets the overflow flag. End: every active entry
// is read. Vertical: entries are read in order until a y >= y_high, the hit limit or
// the end of the store; the single store read port makes every scan serial.
// Reset is synchronous, active low; store contents need no clearing.
// Output stalls hold the scan at the next hit; one hit waits in the out register.
`default_nettype none
module hv_segment_sweep_intersect_core
    import hvss_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire  [1:0]   i_kind,
    input  wire t_coord  i_x,
    input  wire t_coord  i_y_low,
    input  wire t_coord  i_y_high,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output t_coord       o_hit_x,
    output t_coord       o_hit_y,
    output logic         o_last,
    output logic         o_overflowed
);

    t_state             r_state, n_state;
    t_cnt               r_cnt, n_cnt;
    t_cnt               r_pos, n_pos;
    logic               r_ovf, n_ovf;
    logic               r_found, n_found;
    logic               r_pend, n_pend;
    t_coord             r_pend_y, n_pend_y;
    logic [HIT_W-1:0]   r_nhit, n_nhit;
    t_coord             r_x, n_x;
    t_coord             r_ylo, n_ylo;
    t_coord             r_yhi, n_yhi;
    logic               r_ovalid, n_ovalid;
    t_coord             r_ohx, n_ohx;
    t_coord             r_ohy, n_ohy;
    logic               r_olast, n_olast;
    logic               r_oovf, n_oovf;

    t_mem_req           mem_req;
    t_coord             rdata;
    t_cmp_res           cmp;
    logic               slot_free;

    hvss_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    hvss_cmp u_cmp (
        .i_data   (rdata),
        .i_key_lo (r_ylo),
        .i_key_hi (r_yhi),
        .o_res    (cmp)
    );

    assign slot_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_found  <= n_found;
        r_pend_y <= n_pend_y;
        r_nhit   <= n_nhit;
        r_x      <= n_x;
        r_ylo    <= n_ylo;
        r_yhi    <= n_yhi;
        r_ohx    <= n_ohx;
        r_ohy    <= n_ohy;
        r_olast  <= n_olast;
        r_oovf   <= n_oovf;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_ovf    = r_ovf;
        n_found  = r_found;
        n_pend   = r_pend;
        n_pend_y = r_pend_y;
        n_nhit   = r_nhit;
        n_x      = r_x;
        n_ylo    = r_ylo;
        n_yhi    = r_yhi;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ohx    = r_ohx;
        n_ohy    = r_ohy;
        n_olast  = r_olast;
        n_oovf   = r_oovf;
        mem_req  = '0;
        o_in_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_x     = i_x;
                    n_ylo   = i_y_low;
                    n_yhi   = i_y_high;
                    n_found = 1'b0;
                    n_nhit  = '0;
                    unique case (i_kind)
                        K_START: begin
                            if (r_cnt >= CNT_W'(MAX_ACTIVE)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_pos   = r_cnt;
                                n_state = S_INS_RD;
                            end
                        end
                        K_END: begin
                            n_pos   = '0;
                            n_state = S_REM_RD;
                        end
                        K_VERT: begin
                            n_pos   = '0;
                            n_state = S_VRT_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (r_pos == '0) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = '0;
                    mem_req.wdata = r_ylo;
                    n_cnt         = r_cnt + 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(r_pos - 1'b1);
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(r_pos);
                if (cmp.gt_lo) begin
                    mem_req.wdata = rdata;
                    n_pos         = r_pos - 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    mem_req.wdata = r_ylo;
                    n_cnt         = r_cnt + 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_REM_RD: begin
                if (r_pos == r_cnt) begin
                    if (r_found) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(r_pos);
                    n_state       = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                if (r_found) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = IDX_W'(r_pos - 1'b1);
                    mem_req.wdata = rdata;
                end else if (cmp.eq_lo) begin
                    n_found = 1'b1;
                end
                n_pos   = r_pos + 1'b1;
                n_state = S_REM_RD;
            end
            S_VRT_RD: begin
                if (r_pos == r_cnt) begin
                    n_state = S_FLUSH;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(r_pos);
                    n_state       = S_VRT_CMP;
                end
            end
            S_VRT_CMP: begin
                if (cmp.gt_lo && cmp.lt_hi) begin
                    if (!r_pend || slot_free) begin
                        if (r_pend) begin
                            n_ovalid = 1'b1;
                            n_ohx    = r_x;
                            n_ohy    = r_pend_y;
                            n_olast  = 1'b0;
                            n_oovf   = r_ovf;
                        end
                        n_pend   = 1'b1;
                        n_pend_y = rdata;
                        n_nhit   = r_nhit + 1'b1;
                        if (r_nhit == HIT_W'(MAX_RESULTS - 1)) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_state = S_VRT_RD;
                        end
                    end
                end else if (!cmp.lt_hi) begin
                    // sorted store: nothing further can fall inside the span
                    n_state = S_FLUSH;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = S_VRT_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_ohx    = r_x;
                    n_ohy    = r_pend_y;
                    n_olast  = 1'b1;
                    n_oovf   = r_ovf;
                    n_pend   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_ovalid;
    assign o_hit_x      = r_ohx;
    assign o_hit_y      = r_ohy;
    assign o_last       = r_olast;
    assign o_overflowed = r_oovf;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_ACTIVE))
        else $error("active count beyond store depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("pending hit left behind at idle");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_req.we)
        else $error("store written while idle");

    a_pend_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_VRT_RD || r_state == S_VRT_CMP || r_state == S_FLUSH))
        else $error("pending hit outside vertical scan");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the segment sweep intersection core.
`timescale 1ns / 1ps
module tb_top;
    import hvss_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 200;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         N_SWEEP     = 330;

    typedef struct packed {
        logic [1:0] kind;
        t_coord     x;
        t_coord     y_low;
        t_coord     y_high;
        logic       typed;
        logic [5:0] n_hits;
        t_coord     hit_y;
    } ev_t;

    typedef struct packed {
        t_coord hit_x;
        t_coord hit_y;
        logic   last;
        logic   overflowed;
    } hit_t;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   [1:0] i_kind = '0;
    t_coord i_x         = '0;
    t_coord i_y_low     = '0;
    t_coord i_y_high    = '0;
    logic   i_out_ready = 1'b0;
    logic   o_in_ready;
    logic   o_out_valid;
    t_coord o_hit_x;
    t_coord o_hit_y;
    logic   o_last;
    logic   o_overflowed;

    t_coord      live_y[$];
    logic        ovf_seen = 1'b0;
    hit_t        pending_hits[$];
    ev_t         dir_rows[$];
    int          fails = 0;
    int          hits_seen = 0;
    int          sweep_x = -700;
    bit          steady = 1'b0;
    int unsigned cycle_cnt = 0;

    hv_segment_sweep_intersect_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_x          (i_x),
        .i_y_low      (i_y_low),
        .i_y_high     (i_y_high),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit_x      (o_hit_x),
        .o_hit_y      (o_hit_y),
        .o_last       (o_last),
        .o_overflowed (o_overflowed)
    );

    always #2 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_coord pick_y();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return t_coord'(int'($urandom_range(0, 40)) - 20);
        if (r < 85) return t_coord'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0:       return t_coord'(-32768);
            1:       return t_coord'(32767);
            2:       return t_coord'(-32767);
            default: return t_coord'(32766);
        endcase
    endfunction

    // Advance the sorted store by one item and queue the hits it produces.
    function automatic void sweep_event(input ev_t ev);
        hit_t   found[$];
        hit_t   h;
        t_coord lo;
        t_coord hi;
        int     pos;
        int     n;
        lo = ev.y_low;
        hi = ev.y_high;
        case (ev.kind)
            K_START: begin
                if (live_y.size() >= MAX_ACTIVE) begin
                    ovf_seen = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < live_y.size() && live_y[pos] <= lo) pos++;
                    live_y.insert(pos, lo);
                end
            end
            K_END: begin
                pos = 0;
                while (pos < live_y.size() && live_y[pos] != lo) pos++;
                if (pos < live_y.size()) live_y.delete(pos);
            end
            K_VERT: begin
                for (n = 0; n < live_y.size(); n++) begin
                    if (found.size() < MAX_RESULTS && live_y[n] > lo && live_y[n] < hi)
                        found.insert(found.size(), {ev.x, live_y[n], 1'b0, ovf_seen});
                end
            end
            default: ;
        endcase
        if (ev.typed) begin
            for (n = 0; n < ev.n_hits; n++)
                pending_hits.insert(pending_hits.size(), {ev.x, ev.hit_y, 1'b1, 1'b0});
        end else begin
            for (n = 0; n < found.size(); n++) begin
                h = found[n];
                h.last = (n == found.size() - 1);
                pending_hits.insert(pending_hits.size(), h);
            end
        end
    endfunction

    function automatic ev_t rand_event(input bit fill);
        ev_t ev;
        int  r;
        int  span;
        ev = '0;
        sweep_x += $urandom_range(0, 3);
        ev.x = ($urandom_range(0, 9) == 0) ? t_coord'($urandom_range(0, 65535))
                                           : t_coord'(sweep_x);
        ev.y_high = t_coord'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (!fill && live_y.size() >= 30) r = 50;
        if (fill) r = (r < 35) ? 20 : (r < 55) ? 50 : 80;
        if (r < 3) begin
            ev.kind  = KIND_UNUSED;
            ev.y_low = t_coord'($urandom_range(0, 65535));
        end else if (r < 40) begin
            ev.kind  = K_START;
            ev.y_low = pick_y();
        end else if (r < 70) begin
            ev.kind = K_END;
            if (live_y.size() > 0 && $urandom_range(0, 9) < 8)
                ev.y_low = live_y[$urandom_range(0, live_y.size() - 1)];
            else
                ev.y_low = pick_y();
        end else begin
            ev.kind = K_VERT;
            r = $urandom_range(0, 99);
            if (fill && r < 50) r = 95;
            if (r < 80) begin
                ev.y_low = pick_y();
                span = int'(ev.y_low) + int'($urandom_range(1, 60));
                if ($urandom_range(0, 3) == 0) span = int'($urandom_range(0, 65535)) - 32768;
                ev.y_high = t_coord'((span > 32767) ? 32767 : span);
            end else if (r < 90) begin
                ev.y_high = pick_y();
                ev.y_low  = ($urandom_range(0, 1) == 0) ? ev.y_high
                          : t_coord'(int'(ev.y_high) + int'($urandom_range(0, 30)));
            end else begin
                ev.y_low  = t_coord'(-32768);
                ev.y_high = t_coord'(32767);
            end
        end
        return ev;
    endfunction

    function automatic void add_row(input logic [1:0] kind, input int x, input int lo,
                                    input int hi, input bit typed, input int n,
                                    input int hy);
        dir_rows.insert(dir_rows.size(), {kind, t_coord'(x), t_coord'(lo), t_coord'(hi),
                                          typed, 6'(n), t_coord'(hy)});
    endfunction

    task automatic push_event(input ev_t ev);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= ev.kind;
        i_x        <= ev.x;
        i_y_low    <= ev.y_low;
        i_y_high   <= ev.y_high;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sweep_event(ev);
    endtask

    function automatic void log_mismatch(input string what, input hit_t want, input hit_t got);
        fails++;
        if (fails <= 10)
            $display("%s: want x=%0d y=%0d last=%0b ovf=%0b, got x=%0d y=%0d last=%0b ovf=%0b",
                     what, $signed(want.hit_x), $signed(want.hit_y), want.last,
                     want.overflowed, $signed(got.hit_x), $signed(got.hit_y), got.last,
                     got.overflowed);
    endfunction

    always @(posedge i_clk) begin : hit_check
        hit_t got;
        hit_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            hits_seen++;
            got = {o_hit_x, o_hit_y, o_last, o_overflowed};
            if (pending_hits.size() == 0) begin
                log_mismatch("unexpected hit", '0, got);
            end else begin
                want = pending_hits.pop_front();
                if (got != want) log_mismatch("hit mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : out_side
        bit held;
        int run_len;
        int stall;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && hits_seen >= 48) begin
                // long back-pressure: input side must fill up and stall
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            i_out_ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall = steady ? 0 : idle_len();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin : in_side
        ev_t ev;
        int  done;
        int  k;
        add_row(K_VERT,       0, -32768,  32767, 1'b1, 0, 0);
        add_row(K_START,      0, -32768,  32767, 1'b0, 0, 0);
        add_row(K_START,      0,  32767, -32768, 1'b0, 0, 0);
        add_row(K_VERT,  -32768, -32768,  32767, 1'b1, 0, 0);
        add_row(K_START,      1,      0,      0, 1'b0, 0, 0);
        add_row(K_VERT,   32767, -32768,  32767, 1'b1, 1, 0);
        add_row(K_START,      2,      0,     -1, 1'b0, 0, 0);
        add_row(K_START,      2,     -1,      0, 1'b0, 0, 0);
        add_row(K_VERT,       3,     -2,      1, 1'b0, 0, 0);
        add_row(K_END,        4,      0,      0, 1'b0, 0, 0);
        add_row(K_END,        4,    123,      0, 1'b0, 0, 0);
        add_row(K_VERT,       5,     10,    -10, 1'b1, 0, 0);
        add_row(K_VERT,       5,      0,      0, 1'b1, 0, 0);
        add_row(KIND_UNUSED,  6,     -1,     -1, 1'b1, 0, 0);
        add_row(K_VERT,       7, -32768,  32767, 1'b0, 0, 0);
        add_row(K_END,        8, -32768,      0, 1'b0, 0, 0);
        add_row(K_END,        8,  32767,      0, 1'b0, 0, 0);
        add_row(K_END,        8,      0,      0, 1'b0, 0, 0);
        add_row(K_END,        8,     -1,      0, 1'b0, 0, 0);
        add_row(K_VERT,       9, -32768,  32767, 1'b1, 0, 0);
        add_row(K_END,       10,      5,      0, 1'b0, 0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) push_event(dir_rows[k]);

        done = 0;
        while (done < N_SWEEP) begin
            steady = (done >= 150 && done < 200);
            ev = rand_event(1'b0);
            push_event(ev);
            if (ev.kind != KIND_UNUSED) done++;
        end
        steady = 1'b0;

        // fill the store, then push it past capacity
        while (live_y.size() < MAX_ACTIVE) begin
            ev = rand_event(1'b0);
            ev.kind  = K_START;
            ev.y_low = pick_y();
            push_event(ev);
        end
        for (k = 0; k < 3; k++) begin
            ev = rand_event(1'b0);
            ev.kind = K_START;
            push_event(ev);
        end
        for (k = 0; k < 20; k++) push_event(rand_event(1'b1));
        i_in_valid <= 1'b0;

        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending_hits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
